// ===== rtl/core/spmpuf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package spmpuf_pkg;

    localparam int MAX_OUT_WIDTH = 4096;
    localparam int MAX_SRC_WIDTH = 8192;

    localparam int SW_W       = 14;
    localparam int OW_W       = 13;
    localparam int COL_W      = 12;
    localparam int BYTE_W     = 8;
    localparam int PAD_W      = 13;
    localparam int STEP_W     = 14;
    localparam int POS_W      = 16;
    localparam int QUOT_W     = 11;
    localparam int BANKS      = 3;
    localparam int BANK_W     = 2;
    localparam int ROW_W      = 12;
    localparam int ROWS       = MAX_OUT_WIDTH;
    localparam int PROD_W     = 24;
    localparam int S_TDATA_W  = 40;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;

    // floor(x/3) for x < 8192 as (x * DIV3_MUL) >> DIV3_SHIFT
    localparam int DIV3_MUL   = 2731;
    localparam int DIV3_SHIFT = 13;

    localparam logic [BYTE_W-1:0] FILTER_UP = 8'd2;

    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_WIDTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RGB_MODE     = 2'd2;

    typedef struct packed {
        logic [SW_W-1:0]  sw;
        logic [OW_W-1:0]  ow;
        logic [PAD_W-1:0] pad;
        logic             rgb;
    } cfg_t;

    typedef struct packed {
        logic                         first;
        logic                         col0;
        logic                         last;
        logic                         rgb;
        logic [BANK_W-1:0]            bank;
        logic [BANKS-1:0]             mask;
        logic [ROW_W-1:0]             row;
        logic [BANKS-1:0][BYTE_W-1:0] sample;
    } line_req_t;

    typedef struct packed {
        logic                         col0;
        logic                         last;
        logic                         rgb;
        logic [BANKS-1:0][BYTE_W-1:0] filt;
    } ser_item_t;

endpackage

`default_nettype wire

// ===== rtl/core/spmpuf_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module spmpuf_cfg (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [spmpuf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [spmpuf_pkg::CFG_DATA_W-1:0]   cfg_data,
    output spmpuf_pkg::cfg_t                         cfg
);

    logic [spmpuf_pkg::SW_W-1:0]  source_width_reg;
    logic [spmpuf_pkg::OW_W-1:0]  output_width_reg;
    logic                         rgb_mode_reg;
    spmpuf_pkg::cfg_t             cfg_reg;
    spmpuf_pkg::cfg_t             cfg_next;

    logic [spmpuf_pkg::SW_W-1:0]  sw_eff;
    logic [spmpuf_pkg::OW_W-1:0]  ow_eff;
    logic [spmpuf_pkg::STEP_W:0]  ow_ch;
    logic signed [spmpuf_pkg::POS_W-1:0] pad_excess;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_width_reg <= spmpuf_pkg::SW_W'(1);
            output_width_reg <= spmpuf_pkg::OW_W'(1);
            rgb_mode_reg     <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                spmpuf_pkg::REG_SOURCE_WIDTH: source_width_reg <= cfg_data;
                spmpuf_pkg::REG_OUTPUT_WIDTH:
                    output_width_reg <= cfg_data[spmpuf_pkg::OW_W-1:0];
                spmpuf_pkg::REG_RGB_MODE:     rgb_mode_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // clamp to the store limits and work out the left pad
    always_comb
    begin
        sw_eff = (source_width_reg > spmpuf_pkg::SW_W'(spmpuf_pkg::MAX_SRC_WIDTH)) ?
                 spmpuf_pkg::SW_W'(spmpuf_pkg::MAX_SRC_WIDTH) : source_width_reg;
        ow_eff = (output_width_reg > spmpuf_pkg::OW_W'(spmpuf_pkg::MAX_OUT_WIDTH)) ?
                 spmpuf_pkg::OW_W'(spmpuf_pkg::MAX_OUT_WIDTH) : output_width_reg;
        ow_ch  = rgb_mode_reg ?
                 ((spmpuf_pkg::STEP_W+1)'(ow_eff) << 1) + (spmpuf_pkg::STEP_W+1)'(ow_eff) :
                 (spmpuf_pkg::STEP_W+1)'(ow_eff);
        pad_excess = $signed(spmpuf_pkg::POS_W'(ow_ch)) - $signed(spmpuf_pkg::POS_W'(sw_eff));
        cfg_next.sw  = sw_eff;
        cfg_next.ow  = ow_eff;
        cfg_next.rgb = rgb_mode_reg;
        cfg_next.pad = (pad_excess > 0) ? pad_excess[spmpuf_pkg::PAD_W:1] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sw  <= spmpuf_pkg::SW_W'(1);
            cfg_reg.ow  <= spmpuf_pkg::OW_W'(1);
            cfg_reg.pad <= '0;
            cfg_reg.rgb <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== rtl/core/spmpuf_prep.sv =====
`timescale 1ns / 1ps
`default_nettype none

module spmpuf_prep (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire spmpuf_pkg::cfg_t                  cfg,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic                              first_row,
    input  wire logic [spmpuf_pkg::COL_W-1:0]      pixel_column,
    input  wire logic [spmpuf_pkg::BYTE_W-1:0]     sub0,
    input  wire logic [spmpuf_pkg::BYTE_W-1:0]     sub1,
    input  wire logic [spmpuf_pkg::BYTE_W-1:0]     sub2,
    output logic                                   req_valid,
    input  wire logic                              req_ready,
    output spmpuf_pkg::line_req_t                  req
);

    // stage A: captured item
    logic                                          a_valid_reg;
    logic                                          a_first_reg;
    logic [spmpuf_pkg::COL_W-1:0]                  a_col_reg;
    logic [spmpuf_pkg::BANKS-1:0][spmpuf_pkg::BYTE_W-1:0] a_sub_reg;

    // stage B: column products
    logic                                          b_valid_reg;
    logic                                          b_first_reg;
    logic                                          b_col0_reg;
    logic                                          b_last_reg;
    logic [spmpuf_pkg::COL_W-1:0]                  b_col_reg;
    logic [spmpuf_pkg::STEP_W-1:0]                 b_step_reg;
    logic [spmpuf_pkg::QUOT_W-1:0]                 b_quot_reg;
    logic [spmpuf_pkg::BANKS-1:0][spmpuf_pkg::BYTE_W-1:0] b_sub_reg;

    // stage C: samples and store address
    logic                                          c_valid_reg;
    spmpuf_pkg::line_req_t                         c_req_reg;
    spmpuf_pkg::line_req_t                         c_req_next;

    logic a_ready, b_ready, c_ready;

    logic [spmpuf_pkg::PROD_W-1:0]                 a_prod;
    logic [spmpuf_pkg::STEP_W-1:0]                 a_step;
    logic                                          a_col_ok;
    logic                                          a_last;

    logic signed [spmpuf_pkg::POS_W-1:0]           b_pos [spmpuf_pkg::BANKS];
    logic [spmpuf_pkg::BANKS-1:0][spmpuf_pkg::BYTE_W-1:0] b_pick;
    logic [spmpuf_pkg::BYTE_W:0]                   b_sum;
    logic [spmpuf_pkg::COL_W-1:0]                  b_quot3;
    logic [spmpuf_pkg::COL_W-1:0]                  b_rem;

    assign c_ready  = !c_valid_reg || req_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_ready)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            a_first_reg <= first_row;
            a_col_reg   <= pixel_column;
            a_sub_reg   <= {sub2, sub1, sub0};
        end
    end

    always_comb
    begin
        a_prod   = spmpuf_pkg::PROD_W'(a_col_reg) * spmpuf_pkg::PROD_W'(spmpuf_pkg::DIV3_MUL);
        a_step   = (spmpuf_pkg::STEP_W'(a_col_reg) << 1) +
                   (cfg.rgb ? spmpuf_pkg::STEP_W'(a_col_reg) : '0);
        a_col_ok = ({1'b0, a_col_reg} < cfg.ow);
        a_last   = ({1'b0, a_col_reg} == (cfg.ow - spmpuf_pkg::OW_W'(1)));
    end

    // drop columns outside the row here
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (b_ready)
        begin
            b_valid_reg <= a_valid_reg && a_col_ok;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_ready && a_valid_reg)
        begin
            b_first_reg <= a_first_reg;
            b_col0_reg  <= (a_col_reg == '0);
            b_last_reg  <= a_last;
            b_col_reg   <= a_col_reg;
            b_step_reg  <= a_step;
            b_quot_reg  <= a_prod[spmpuf_pkg::DIV3_SHIFT +: spmpuf_pkg::QUOT_W];
            b_sub_reg   <= a_sub_reg;
        end
    end

    always_comb
    begin
        b_pos[0] = $signed(spmpuf_pkg::POS_W'(b_step_reg)) - $signed(spmpuf_pkg::POS_W'(cfg.pad));
        b_pos[1] = b_pos[0] + spmpuf_pkg::POS_W'(1);
        b_pos[2] = b_pos[0] + spmpuf_pkg::POS_W'(2);
        for (int k = 0; k < spmpuf_pkg::BANKS; k++)
        begin
            // zero any subpixel that falls off either side of the source row
            if (!b_pos[k][spmpuf_pkg::POS_W-1] &&
                (b_pos[k] < $signed(spmpuf_pkg::POS_W'(cfg.sw))))
            begin
                b_pick[k] = b_sub_reg[k];
            end
            else
            begin
                b_pick[k] = '0;
            end
        end
        b_sum   = (spmpuf_pkg::BYTE_W+1)'(b_pick[0]) + (spmpuf_pkg::BYTE_W+1)'(b_pick[1]);
        b_quot3 = (spmpuf_pkg::COL_W'(b_quot_reg) << 1) + spmpuf_pkg::COL_W'(b_quot_reg);
        b_rem   = b_col_reg - b_quot3;

        c_req_next.first = b_first_reg;
        c_req_next.col0  = b_col0_reg;
        c_req_next.last  = b_last_reg;
        c_req_next.rgb   = cfg.rgb;
        if (cfg.rgb)
        begin
            c_req_next.bank   = '0;
            c_req_next.mask   = '1;
            c_req_next.row    = b_col_reg;
            c_req_next.sample = b_pick;
        end
        else
        begin
            // grey byte k of the row lives in bank k mod 3, row k / 3
            c_req_next.bank   = b_rem[spmpuf_pkg::BANK_W-1:0];
            c_req_next.mask   = spmpuf_pkg::BANKS'(1) << b_rem[spmpuf_pkg::BANK_W-1:0];
            c_req_next.row    = spmpuf_pkg::ROW_W'(b_quot_reg);
            c_req_next.sample = {{(spmpuf_pkg::BANKS-1){8'd0}}, b_sum[spmpuf_pkg::BYTE_W:1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (c_ready)
        begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_ready && b_valid_reg)
        begin
            c_req_reg <= c_req_next;
        end
    end

    assign req_valid = c_valid_reg;
    assign req       = c_req_reg;

endmodule

`default_nettype wire

// ===== rtl/core/spmpuf_line.sv =====
`timescale 1ns / 1ps
`default_nettype none

module spmpuf_line (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  req_valid,
    output logic                       req_ready,
    input  wire spmpuf_pkg::line_req_t req,
    output logic                       item_valid,
    input  wire logic                  item_ready,
    output spmpuf_pkg::ser_item_t      item
);

    logic [spmpuf_pkg::BYTE_W-1:0] store_mem [spmpuf_pkg::BANKS][spmpuf_pkg::ROWS];

    logic                                                 d_valid_reg;
    logic                                                 d_first_reg;
    logic                                                 d_col0_reg;
    logic                                                 d_last_reg;
    logic                                                 d_rgb_reg;
    logic [spmpuf_pkg::BANK_W-1:0]                        d_bank_reg;
    logic [spmpuf_pkg::BANKS-1:0][spmpuf_pkg::BYTE_W-1:0] d_sample_reg;
    logic [spmpuf_pkg::BYTE_W-1:0]                        prev_reg [spmpuf_pkg::BANKS];

    logic                                                 req_fire;
    logic [spmpuf_pkg::BANKS-1:0][spmpuf_pkg::BYTE_W-1:0] wdata;
    logic [spmpuf_pkg::BYTE_W-1:0]                        prev [spmpuf_pkg::BANKS];
    logic [spmpuf_pkg::BYTE_W-1:0]                        grey_prev;

    assign req_ready = !d_valid_reg || item_ready;
    assign req_fire  = req_valid && req_ready;

    always_comb
    begin
        for (int k = 0; k < spmpuf_pkg::BANKS; k++)
        begin
            wdata[k] = req.rgb ? req.sample[k] : req.sample[0];
        end
    end

    // read the old row and write the new sample bytes at the same edge; the next item
    // sees this write since it reads no earlier than the following edge
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            for (int k = 0; k < spmpuf_pkg::BANKS; k++)
            begin
                prev_reg[k] <= store_mem[k][req.row];
                if (req.mask[k])
                begin
                    store_mem[k][req.row] <= wdata[k];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
        end
        else if (req_ready)
        begin
            d_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            d_first_reg  <= req.first;
            d_col0_reg   <= req.col0;
            d_last_reg   <= req.last;
            d_rgb_reg    <= req.rgb;
            d_bank_reg   <= req.bank;
            d_sample_reg <= req.sample;
        end
    end

    always_comb
    begin
        for (int k = 0; k < spmpuf_pkg::BANKS; k++)
        begin
            prev[k] = d_first_reg ? '0 : prev_reg[k];
        end
        case (d_bank_reg)
            2'd0:    grey_prev = prev[0];
            2'd1:    grey_prev = prev[1];
            2'd2:    grey_prev = prev[2];
            default: grey_prev = prev[0];
        endcase

        item.col0 = d_col0_reg;
        item.last = d_last_reg;
        item.rgb  = d_rgb_reg;
        if (d_rgb_reg)
        begin
            for (int k = 0; k < spmpuf_pkg::BANKS; k++)
            begin
                item.filt[k] = d_sample_reg[k] - prev[k];
            end
        end
        else
        begin
            item.filt    = '0;
            item.filt[0] = d_sample_reg[0] - grey_prev;
        end
    end

    assign item_valid = d_valid_reg;

endmodule

`default_nettype wire

// ===== rtl/core/spmpuf_ser.sv =====
`timescale 1ns / 1ps
`default_nettype none

module spmpuf_ser (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          item_valid,
    output logic                               item_ready,
    input  wire spmpuf_pkg::ser_item_t         item,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [spmpuf_pkg::BYTE_W-1:0]      m_tdata,
    output logic                               m_tlast
);

    logic [3:0][spmpuf_pkg::BYTE_W-1:0] byte_reg;
    logic [3:0][spmpuf_pkg::BYTE_W-1:0] byte_next;
    logic [2:0]                         cnt_reg;
    logic [2:0]                         cnt_next;
    logic [1:0]                         pos_reg;
    logic [1:0]                         pos_next;
    logic                               last_reg;
    logic                               last_next;

    logic out_fire;
    logic load;

    assign m_tvalid   = (cnt_reg != '0);
    assign out_fire   = m_tvalid && m_tready;
    assign item_ready = (cnt_reg == '0) || ((cnt_reg == 3'd1) && m_tready);
    assign load       = item_valid && item_ready;

    always_comb
    begin
        byte_next = byte_reg;
        cnt_next  = cnt_reg;
        pos_next  = pos_reg;
        last_next = last_reg;
        if (out_fire)
        begin
            cnt_next = cnt_reg - 3'd1;
            pos_next = pos_reg + 2'd1;
        end
        if (load)
        begin
            // lead the row with the filter-type byte
            pos_next  = '0;
            last_next = item.last;
            cnt_next  = (item.rgb ? 3'd3 : 3'd1) + (item.col0 ? 3'd1 : 3'd0);
            if (item.col0)
            begin
                byte_next = {item.filt, spmpuf_pkg::FILTER_UP};
            end
            else
            begin
                byte_next = {8'd0, item.filt};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            pos_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

    assign m_tdata = byte_reg[pos_reg];
    assign m_tlast = last_reg && (cnt_reg == 3'd1);

endmodule

`default_nettype wire

// ===== rtl/core/subpixel_map_png_up_filter.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Role    Fields (lowest bit first)
// cfg       write   cfg_index: register; cfg_data: value
// s_axis    in      tdata: pixel_column[11:0], sub0, sub1, sub2, 4 zero bits; tuser: first_row
// m_axis    out     tdata: out_byte; tlast: row_last
//
// Each pixel passes five register stages (capture, column products, sample
// select, line store access, byte serializer); a new pixel may enter every
// cycle while the serializer is free. The output emits one byte per cycle
// while m_tready is high: one per pixel in grey mode, three in RGB mode,
// plus the filter-type byte at column 0. Reset clears control state and
// restores register defaults; the line store holds no defined contents until
// a row writes it. A stall on m_axis holds every stage and drops nothing.

module subpixel_map_png_up_filter (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [spmpuf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [spmpuf_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    input  wire logic [spmpuf_pkg::S_TDATA_W-1:0]       s_tdata,  // pixel_column, sub0, sub1, sub2
    input  wire logic                                   s_tuser,  // first_row
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    output logic [spmpuf_pkg::BYTE_W-1:0]               m_tdata,  // out_byte
    output logic                                        m_tlast
);

    spmpuf_pkg::cfg_t       cfg;
    spmpuf_pkg::line_req_t  req;
    spmpuf_pkg::ser_item_t  item;
    logic                   req_valid;
    logic                   req_ready;
    logic                   item_valid;
    logic                   item_ready;

    spmpuf_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    spmpuf_prep u_prep (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .first_row    (s_tuser),
        .pixel_column (s_tdata[11:0]),
        .sub0         (s_tdata[19:12]),
        .sub1         (s_tdata[27:20]),
        .sub2         (s_tdata[35:28]),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .req          (req)
    );

    spmpuf_line u_line (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item)
    );

    spmpuf_ser u_ser (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire
